/* hw/rtl/bhr_pkg.sv */
// Package: shared widths, constants, register map and sequencer states for the heart rate block.
package bhr_pkg;

  localparam int TIME_W = 32;
  localparam int HR_W   = 16;
  localparam int MAXI_W = 16;
  localparam int WARM_W = 4;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [HR_W-1:0]   BPM_NUMERATOR    = 16'd60000;
  localparam logic [HR_W-1:0]   BPM_SATURATED    = 16'hFFFF;
  localparam logic [MAXI_W-1:0] MAX_INTERVAL_RST = 16'd2000;
  localparam logic [WARM_W-1:0] WARMUP_RST       = 4'd3;

  // register index taken from paddr[2]
  localparam logic REG_MAX_INTERVAL = 1'b0;
  localparam logic REG_WARMUP_BEATS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SUM,
    ST_MEAN,
    ST_DIV,
    ST_DONE
  } bhr_state_t;

endpackage

/* hw/rtl/bhr_ifs.sv */
// Interfaces: beat input channel and heart rate result channel.
interface bhr_in_if
  import bhr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] beat_time_ms;

  modport source (output valid, output beat_time_ms, input ready);
  modport sink   (input valid, input beat_time_ms, output ready);
endinterface

interface bhr_out_if
  import bhr_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [HR_W-1:0] heart_rate_bpm;
  logic            reporting;
  logic            error_restart;

  modport source (output valid, output heart_rate_bpm, output reporting,
                  output error_restart, input ready);
  modport sink   (input valid, input heart_rate_bpm, input reporting,
                  input error_restart, output ready);
endinterface

/* hw/rtl/beat_interval_heart_rate_top.sv */
// Top level: heart rate from a moving average of beat intervals, with APB register port.
//
//  channel   dir  handshake            payload
//  in_if     in   valid/ready          beat_time_ms[31:0]
//  out_if    out  valid/ready          heart_rate_bpm[15:0], reporting, error_restart
//  APB       in   psel/penable/pready  max_interval_ms @0x0, warmup_beats @0x4
//
// Per beat: a warm-up or error beat is accepted, evaluated and loaded as a result; a
// measured beat also runs the window sum, the mean and, unless the mean is zero, the divider.
// The window sum walks the window one entry per cycle, the mean is a reciprocal
// multiply, and 60000/mean runs through a restoring divider at one quotient bit per cycle.
// Reset (rst_n, synchronous) restores registers to 2000 ms / 3 beats and restarts warm-up.
// A result waits in the output register; the sequencer stalls in its final state until
// that register is free, and in_if.ready is high only while the sequencer is idle.
module beat_interval_heart_rate_top
  import bhr_pkg::*;
#(
  parameter int WINDOW_LEN = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  bhr_in_if.sink            in_if,
  bhr_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // window sum never wraps: WINDOW_LEN entries of 16 bits
  localparam int SUM_W = HR_W + $clog2(WINDOW_LEN);
  localparam int IDX_W = $clog2(WINDOW_LEN);
  // sum / WINDOW_LEN == (sum * RECIP) >> RECIP_SH, exact for every sum below 2^SUM_W
  localparam int RECIP_SH = SUM_W + IDX_W;
  localparam int PROD_W   = 2 * SUM_W + 1;
  localparam logic [SUM_W:0] RECIP =
    (SUM_W+1)'(((1 << RECIP_SH) + WINDOW_LEN - 1) / WINDOW_LEN);

  bhr_state_t state_r, state_nxt;

  // configuration registers
  logic [MAXI_W-1:0] max_int_r, max_int_nxt;
  logic [WARM_W-1:0] warmup_r, warmup_nxt;

  // measurement state
  logic [WARM_W-1:0] warm_cnt_r, warm_cnt_nxt;
  logic [TIME_W-1:0] prev_time_r, prev_time_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [HR_W-1:0]   win_r   [WINDOW_LEN];
  logic [HR_W-1:0]   win_nxt [WINDOW_LEN];
  logic              unfilled_r, unfilled_nxt;

  // sequencer work registers
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [HR_W-1:0]   res_hr_r, res_hr_nxt;
  logic              res_rep_r, res_rep_nxt;
  logic              res_err_r, res_err_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [HR_W-1:0]   out_hr_r, out_hr_nxt;
  logic              out_rep_r, out_rep_nxt;
  logic              out_err_r, out_err_nxt;

  // divider hookup
  logic              div_start;
  logic [SUM_W-1:0]  div_dividend;
  logic [HR_W-1:0]   div_divisor;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;

  logic [TIME_W-1:0] interval;
  logic [PROD_W-1:0] mean_prod;
  logic [HR_W-1:0]   mean;
  logic              cfg_wr;

  bhr_div #(
    .DVD_W (SUM_W),
    .DVS_W (HR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign interval  = now_r - prev_time_r;   // modulo 2^32
  assign cfg_wr    = psel && penable && pwrite;
  // mean of the window; at most 65535 since every entry is 16 bits
  assign mean_prod = PROD_W'(sum_r) * PROD_W'(RECIP);
  assign mean      = mean_prod[RECIP_SH +: HR_W];

  always_comb begin
    state_nxt     = state_r;
    max_int_nxt   = max_int_r;
    warmup_nxt    = warmup_r;
    warm_cnt_nxt  = warm_cnt_r;
    prev_time_nxt = prev_time_r;
    now_nxt       = now_r;
    win_nxt       = win_r;
    unfilled_nxt  = unfilled_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    res_hr_nxt    = res_hr_r;
    res_rep_nxt   = res_rep_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r;
    out_hr_nxt    = out_hr_r;
    out_rep_nxt   = out_rep_r;
    out_err_nxt   = out_err_r;
    div_start     = 1'b0;
    div_dividend  = '0;
    div_divisor   = '0;

    if (cfg_wr) begin
      if (paddr[2] == REG_WARMUP_BEATS) begin
        warmup_nxt = pwdata[WARM_W-1:0];
      end else begin
        max_int_nxt = pwdata[MAXI_W-1:0];
      end
    end

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          now_nxt   = in_if.beat_time_ms;
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (warm_cnt_r < warmup_r) begin
          // warm-up beat: count only; the last one sets the time reference
          warm_cnt_nxt = warm_cnt_r + 1'b1;
          if (warm_cnt_nxt == warmup_r) begin
            prev_time_nxt = now_r;
            for (int i = 0; i < WINDOW_LEN; i++) begin
              win_nxt[i] = '0;
            end
          end
          res_hr_nxt  = '0;
          res_rep_nxt = 1'b0;
          res_err_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end else if (interval > {{(TIME_W-MAXI_W){1'b0}}, max_int_r}) begin
          // too long: full restart of measurement
          warm_cnt_nxt  = '0;
          prev_time_nxt = '0;
          for (int i = 0; i < WINDOW_LEN; i++) begin
            win_nxt[i] = '0;
          end
          unfilled_nxt = 1'b1;
          res_hr_nxt   = '0;
          res_rep_nxt  = 1'b0;
          res_err_nxt  = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          // interval fits 16 bits here since it is at most max_interval_ms
          prev_time_nxt = now_r;
          for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            win_nxt[i] = unfilled_r ? interval[HR_W-1:0] : win_r[i+1];
          end
          win_nxt[WINDOW_LEN-1] = interval[HR_W-1:0];
          unfilled_nxt = 1'b0;
          idx_nxt      = '0;
          sum_nxt      = '0;
          state_nxt    = ST_SUM;
        end
      end

      ST_SUM: begin
        // rotate the window once around, adding the head entry each cycle
        sum_nxt = sum_r + SUM_W'(win_r[0]);
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[WINDOW_LEN-1] = win_r[0];
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_W'(WINDOW_LEN - 1)) begin
          state_nxt = ST_MEAN;
        end
      end

      ST_MEAN: begin
        res_rep_nxt = 1'b1;
        res_err_nxt = 1'b0;
        if (mean == '0) begin
          res_hr_nxt = BPM_SATURATED;
          state_nxt  = ST_DONE;
        end else begin
          div_start    = 1'b1;
          div_dividend = SUM_W'(BPM_NUMERATOR);
          div_divisor  = mean;
          state_nxt    = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          res_hr_nxt = div_quo[HR_W-1:0];
          state_nxt  = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_hr_nxt    = res_hr_r;
          out_rep_nxt   = res_rep_r;
          out_err_nxt   = res_err_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_int_r   <= MAX_INTERVAL_RST;
      warmup_r    <= WARMUP_RST;
      warm_cnt_r  <= '0;
      prev_time_r <= '0;
      unfilled_r  <= 1'b1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      max_int_r   <= max_int_nxt;
      warmup_r    <= warmup_nxt;
      warm_cnt_r  <= warm_cnt_nxt;
      prev_time_r <= prev_time_nxt;
      unfilled_r  <= unfilled_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
    end
    now_r     <= now_nxt;
    idx_r     <= idx_nxt;
    sum_r     <= sum_nxt;
    res_hr_r  <= res_hr_nxt;
    res_rep_r <= res_rep_nxt;
    res_err_r <= res_err_nxt;
    out_hr_r  <= out_hr_nxt;
    out_rep_r <= out_rep_nxt;
    out_err_r <= out_err_nxt;
  end

  assign in_if.ready           = (state_r == ST_IDLE);
  assign out_if.valid          = out_valid_r;
  assign out_if.heart_rate_bpm = out_hr_r;
  assign out_if.reporting      = out_rep_r;
  assign out_if.error_restart  = out_err_r;

  // register readback, word aligned
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WARMUP_BEATS) ?
                  APB_DW'(warmup_r) : APB_DW'(max_int_r);

endmodule

/* hw/rtl/bhr_div.sv */
// Restoring divider: one quotient bit per cycle, used for the bpm division.
module bhr_div #(
  parameter int DVD_W = 20,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    shifted  = {rem_r, quo_r[DVD_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the top bit of the trial is the borrow
      if (!diff[DVS_W]) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
